// File: src/rcsb_pkg.sv
`default_nettype none

package rcsb_pkg;

	typedef enum logic [2:0] {
		SW_OFF      = 3'd0,
		SW_HIGH     = 3'd1,
		SW_LOW      = 3'd2,
		SW_WAIT_OFF = 3'd3,
		SW_WAIT_CFG = 3'd4
	} sw_t;

	typedef enum logic [2:0] {
		PH_INIT      = 3'd0,
		PH_OFF       = 3'd1,
		PH_ON        = 3'd2,
		PH_SW_OFF    = 3'd3,
		PH_SW_ON     = 3'd4,
		PH_CFG       = 3'd5,
		PH_CH_MODE   = 3'd6,
		PH_CH_BRIGHT = 3'd7
	} ph_t;

	typedef enum logic [1:0] {
		FS_OFF    = 2'd0,
		FS_BOTH   = 2'd1,
		FS_FOG    = 2'd2,
		FS_SEARCH = 2'd3
	} fs_t;

	typedef enum logic [1:0] {
		SIDE_NORMAL = 2'd0,
		SIDE_BEACON = 2'd1,
		SIDE_CFG    = 2'd2
	} side_t;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_START      = 2'd1,
		OP_LIGHTS_OFF = 2'd2
	} op_t;

	localparam logic [2:0] CFG_HIGH_THR   = 3'd0;
	localparam logic [2:0] CFG_LOW_THR    = 3'd1;
	localparam logic [2:0] CFG_SHORT_US   = 3'd2;
	localparam logic [2:0] CFG_LONG_US    = 3'd3;
	localparam logic [2:0] CFG_XLONG_US   = 3'd4;
	localparam logic [2:0] CFG_TOGGLE_US  = 3'd5;
	localparam logic [2:0] CFG_INIT_US    = 3'd6;
	localparam logic [2:0] CFG_PAUSE_US   = 3'd7;

	localparam logic [11:0] CENTER_LOW     = 12'd1400;
	localparam logic [11:0] CENTER_HIGH    = 12'd1600;
	localparam logic [31:0] BRIGHT_DARK_US = 32'd1000000;

	typedef struct packed {
		logic [11:0] high_thr;
		logic [11:0] low_thr;
		logic [30:0] short_us;
		logic [30:0] long_us;
		logic [30:0] xlong_us;
		logic [30:0] toggle_us;
		logic [30:0] init_us;
		logic [30:0] pause_us;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now_us;
		logic [11:0] channel_value;
		logic        headlights_on;
	} item_t;

	typedef struct packed {
		logic [2:0] switch_phase_out;
		logic [2:0] small_phase_out;
		logic [2:0] big_phase_out;
		logic       fog_lamp_on;
		logic       search_light_on;
		logic [1:0] side_mode;
		logic       big_beacon_on;
		logic       small_beacon_on;
	} res_t;

endpackage

`default_nettype wire

// File: src/rcsb_cfg.sv
`default_nettype none

module rcsb_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_addr,
	input  wire logic [30:0]   cfg_data,
	output rcsb_pkg::cfg_t     cfg
);

	rcsb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_thr  <= 12'd1800;
			cfg_q.low_thr   <= 12'd1200;
			cfg_q.short_us  <= 31'd50000;
			cfg_q.long_us   <= 31'd1000000;
			cfg_q.xlong_us  <= 31'd3000000;
			cfg_q.toggle_us <= 31'd50000;
			cfg_q.init_us   <= 31'd2500000;
			cfg_q.pause_us  <= 31'd200000;
		end else if (cfg_we) begin
			case (cfg_addr)
				rcsb_pkg::CFG_HIGH_THR:  cfg_q.high_thr  <= cfg_data[11:0];
				rcsb_pkg::CFG_LOW_THR:   cfg_q.low_thr   <= cfg_data[11:0];
				rcsb_pkg::CFG_SHORT_US:  cfg_q.short_us  <= cfg_data;
				rcsb_pkg::CFG_LONG_US:   cfg_q.long_us   <= cfg_data;
				rcsb_pkg::CFG_XLONG_US:  cfg_q.xlong_us  <= cfg_data;
				rcsb_pkg::CFG_TOGGLE_US: cfg_q.toggle_us <= cfg_data;
				rcsb_pkg::CFG_INIT_US:   cfg_q.init_us   <= cfg_data;
				rcsb_pkg::CFG_PAUSE_US:  cfg_q.pause_us  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: src/rcsb_core.sv
`default_nettype none

module rcsb_core #(
	parameter int TOGGLE_STEPS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire rcsb_pkg::item_t item,
	input  wire rcsb_pkg::cfg_t  cfg,
	output rcsb_pkg::res_t      res
);

	localparam int CW = $clog2(TOGGLE_STEPS + 1);
	localparam logic [CW-1:0] STEPS = CW'(TOGGLE_STEPS);

	rcsb_pkg::sw_t   sw_q,   sw_d;
	rcsb_pkg::ph_t   bp_q,   bp_d;
	rcsb_pkg::ph_t   sp_q,   sp_d;
	rcsb_pkg::fs_t   fs_q,   fs_d;
	rcsb_pkg::side_t side_q, side_d;
	logic [31:0]     press_q, press_d;
	logic [31:0]     sdl_q,   sdl_d;
	logic [31:0]     bdl_q,   bdl_d;
	logic [CW-1:0]   scnt_q,  scnt_d;
	logic            snl_q,   snl_d;
	logic            sos_q,   sos_d;
	logic [1:0]      bst_q,   bst_d;
	logic            sl_q,    sl_d;
	logic            bl_q,    bl_d;

	logic [31:0] now;
	logic [11:0] val;
	logic [31:0] dt;
	logic        held_short, held_long, held_xl;
	logic        centred, is_high, is_low;
	logic [31:0] toggle_dl, init_dl, pause_dl, dark_dl;
	logic [CW-1:0] scnt_inc;

	function automatic logic reached(input logic [31:0] t, input logic [31:0] dl);
		logic [31:0] d;
		d = t - dl;
		return !d[31];
	endfunction

	assign now        = item.now_us;
	assign val        = item.channel_value;
	assign dt         = now - press_q;
	assign held_short = !dt[31] && (dt[30:0] >= cfg.short_us);
	assign held_long  = !dt[31] && (dt[30:0] >= cfg.long_us);
	assign held_xl    = !dt[31] && (dt[30:0] >= cfg.xlong_us);
	assign centred    = (val > rcsb_pkg::CENTER_LOW) && (val < rcsb_pkg::CENTER_HIGH);
	assign is_high    = val > cfg.high_thr;
	assign is_low     = val < cfg.low_thr;
	assign toggle_dl  = now + {1'b0, cfg.toggle_us};
	assign init_dl    = now + {1'b0, cfg.init_us};
	assign pause_dl   = now + {1'b0, cfg.pause_us};
	assign dark_dl    = now + rcsb_pkg::BRIGHT_DARK_US;
	assign scnt_inc   = scnt_q + CW'(1);

	always_comb begin
		sw_d    = sw_q;
		bp_d    = bp_q;
		sp_d    = sp_q;
		fs_d    = fs_q;
		side_d  = side_q;
		press_d = press_q;
		sdl_d   = sdl_q;
		bdl_d   = bdl_q;
		scnt_d  = scnt_q;
		snl_d   = snl_q;
		sos_d   = sos_q;
		bst_d   = bst_q;
		sl_d    = sl_q;
		bl_d    = bl_q;

		case (item.op)
			rcsb_pkg::OP_TICK: begin
				if (bp_q == rcsb_pkg::PH_CFG || bp_q == rcsb_pkg::PH_CH_MODE ||
				    bp_q == rcsb_pkg::PH_CH_BRIGHT) begin
					// setup mode: big beacon pulse trains and switch handling only
					if (bp_q == rcsb_pkg::PH_CH_MODE && reached(now, bdl_q)) begin
						bl_d  = 1'b1;
						bst_d = 2'd0;
						bp_d  = rcsb_pkg::PH_CFG;
					end
					if (bp_q == rcsb_pkg::PH_CH_BRIGHT && reached(now, bdl_q)) begin
						case (bst_q)
							2'd1: begin
								bl_d  = 1'b1;
								bst_d = 2'd2;
								bdl_d = pause_dl;
							end
							2'd2: begin
								bl_d  = 1'b0;
								bst_d = 2'd3;
								bdl_d = dark_dl;
							end
							default: begin
								bl_d  = 1'b1;
								bst_d = 2'd0;
								bp_d  = rcsb_pkg::PH_CFG;
							end
						endcase
					end
					case (sw_q)
						rcsb_pkg::SW_OFF: begin
							if (is_high) begin
								sw_d    = rcsb_pkg::SW_HIGH;
								press_d = now;
							end else if (is_low) begin
								sw_d    = rcsb_pkg::SW_LOW;
								press_d = now;
							end
						end
						rcsb_pkg::SW_HIGH: begin
							if (held_xl) begin
								bl_d   = 1'b0;
								bst_d  = 2'd0;
								bp_d   = rcsb_pkg::PH_OFF;
								side_d = rcsb_pkg::SIDE_NORMAL;
								sw_d   = rcsb_pkg::SW_WAIT_OFF;
							end else if (centred) begin
								sw_d = rcsb_pkg::SW_OFF;
								if (held_short && bp_d == rcsb_pkg::PH_CFG) begin
									bp_d  = rcsb_pkg::PH_CH_MODE;
									bl_d  = 1'b0;
									bst_d = 2'd1;
									bdl_d = pause_dl;
								end
							end
						end
						rcsb_pkg::SW_LOW: begin
							if (centred) begin
								sw_d = rcsb_pkg::SW_OFF;
								if (held_short && bp_d == rcsb_pkg::PH_CFG) begin
									bp_d  = rcsb_pkg::PH_CH_BRIGHT;
									bl_d  = 1'b0;
									bst_d = 2'd1;
									bdl_d = dark_dl;
								end
							end
						end
						rcsb_pkg::SW_WAIT_OFF: begin
							if (centred)
								sw_d = rcsb_pkg::SW_OFF;
						end
						default: ;
					endcase
				end else begin
					if (bp_q == rcsb_pkg::PH_INIT && reached(now, bdl_q)) begin
						bl_d  = 1'b0;
						bst_d = 2'd0;
						bp_d  = rcsb_pkg::PH_OFF;
					end
					if (sp_q == rcsb_pkg::PH_SW_OFF && reached(now, sdl_q)) begin
						sl_d   = snl_q;
						snl_d  = !snl_q;
						sdl_d  = toggle_dl;
						scnt_d = scnt_inc;
						if (scnt_inc >= STEPS) begin
							scnt_d = '0;
							sp_d   = rcsb_pkg::PH_OFF;
						end
					end
					if (sp_q == rcsb_pkg::PH_SW_ON) begin
						if (!sos_q) begin
							sl_d  = 1'b0;
							sos_d = 1'b1;
							sdl_d = toggle_dl;
						end else if (reached(now, sdl_q)) begin
							sl_d  = 1'b1;
							sos_d = 1'b0;
							sp_d  = rcsb_pkg::PH_ON;
						end
					end
					case (sw_q)
						rcsb_pkg::SW_OFF: begin
							if (is_high) begin
								sw_d    = rcsb_pkg::SW_HIGH;
								press_d = now;
							end else if (is_low) begin
								sw_d    = rcsb_pkg::SW_LOW;
								press_d = now;
							end
						end
						rcsb_pkg::SW_HIGH: begin
							if (held_long) begin
								if (bp_d == rcsb_pkg::PH_ON) begin
									bl_d = 1'b0;
									bp_d = rcsb_pkg::PH_OFF;
								end
								if (sp_d == rcsb_pkg::PH_ON) begin
									sp_d   = rcsb_pkg::PH_SW_OFF;
									sl_d   = 1'b0;
									scnt_d = CW'(1);
									snl_d  = 1'b1;
									sos_d  = 1'b0;
									sdl_d  = toggle_dl;
								end
								side_d = rcsb_pkg::SIDE_NORMAL;
								sw_d   = rcsb_pkg::SW_WAIT_CFG;
							end else if (centred) begin
								sw_d = rcsb_pkg::SW_OFF;
								if (held_short && bp_d == rcsb_pkg::PH_OFF &&
								    sp_d == rcsb_pkg::PH_OFF) begin
									bl_d = 1'b1;
									bp_d = rcsb_pkg::PH_ON;
									if (!sos_d) begin
										sp_d  = rcsb_pkg::PH_SW_ON;
										sl_d  = 1'b0;
										sos_d = 1'b1;
										sdl_d = toggle_dl;
									end else if (reached(now, sdl_d)) begin
										sl_d  = 1'b1;
										sos_d = 1'b0;
										sp_d  = rcsb_pkg::PH_ON;
									end
									side_d = rcsb_pkg::SIDE_BEACON;
								end
							end
						end
						rcsb_pkg::SW_LOW: begin
							if (held_long) begin
								fs_d = rcsb_pkg::FS_OFF;
								sw_d = rcsb_pkg::SW_WAIT_OFF;
							end else if (centred) begin
								sw_d = rcsb_pkg::SW_OFF;
								if (held_short) begin
									if (fs_q == rcsb_pkg::FS_OFF)
										fs_d = rcsb_pkg::FS_SEARCH;
									else if (fs_q == rcsb_pkg::FS_SEARCH && item.headlights_on)
										fs_d = rcsb_pkg::FS_FOG;
									else if (fs_q == rcsb_pkg::FS_FOG && item.headlights_on)
										fs_d = rcsb_pkg::FS_BOTH;
								end
							end
						end
						rcsb_pkg::SW_WAIT_OFF: begin
							if (centred)
								sw_d = rcsb_pkg::SW_OFF;
						end
						default: begin
							if (held_xl) begin
								if (bp_d == rcsb_pkg::PH_OFF) begin
									bl_d   = 1'b1;
									bp_d   = rcsb_pkg::PH_CFG;
									side_d = rcsb_pkg::SIDE_CFG;
									sw_d   = rcsb_pkg::SW_WAIT_OFF;
								end
							end else if (centred) begin
								sw_d = rcsb_pkg::SW_OFF;
							end
						end
					endcase
				end
			end
			rcsb_pkg::OP_START: begin
				if (sp_q != rcsb_pkg::PH_SW_OFF) begin
					sp_d   = rcsb_pkg::PH_SW_OFF;
					sl_d   = 1'b0;
					scnt_d = CW'(1);
					snl_d  = 1'b1;
					sos_d  = 1'b0;
					sdl_d  = toggle_dl;
				end else if (reached(now, sdl_q)) begin
					sl_d   = snl_q;
					snl_d  = !snl_q;
					sdl_d  = toggle_dl;
					scnt_d = scnt_inc;
					if (scnt_inc >= STEPS) begin
						scnt_d = '0;
						sp_d   = rcsb_pkg::PH_OFF;
					end
				end
				if (bp_q != rcsb_pkg::PH_INIT) begin
					bp_d  = rcsb_pkg::PH_INIT;
					bl_d  = 1'b1;
					bst_d = 2'd1;
					bdl_d = init_dl;
				end else if (reached(now, bdl_q)) begin
					bl_d  = 1'b0;
					bst_d = 2'd0;
					bp_d  = rcsb_pkg::PH_OFF;
				end
			end
			rcsb_pkg::OP_LIGHTS_OFF: begin
				if (fs_q == rcsb_pkg::FS_FOG)
					fs_d = rcsb_pkg::FS_OFF;
				else if (fs_q == rcsb_pkg::FS_BOTH)
					fs_d = rcsb_pkg::FS_SEARCH;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.small_beacon_on  = sl_d;
		res.big_beacon_on    = bl_d;
		res.side_mode        = side_d;
		res.search_light_on  = (fs_d == rcsb_pkg::FS_BOTH) || (fs_d == rcsb_pkg::FS_SEARCH);
		res.fog_lamp_on      = (fs_d == rcsb_pkg::FS_BOTH) || (fs_d == rcsb_pkg::FS_FOG);
		res.big_phase_out    = bp_d;
		res.small_phase_out  = sp_d;
		res.switch_phase_out = sw_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q    <= rcsb_pkg::SW_OFF;
			bp_q    <= rcsb_pkg::PH_OFF;
			sp_q    <= rcsb_pkg::PH_OFF;
			fs_q    <= rcsb_pkg::FS_OFF;
			side_q  <= rcsb_pkg::SIDE_NORMAL;
			press_q <= '0;
			sdl_q   <= '0;
			bdl_q   <= '0;
			scnt_q  <= '0;
			snl_q   <= 1'b0;
			sos_q   <= 1'b0;
			bst_q   <= 2'd0;
			sl_q    <= 1'b0;
			bl_q    <= 1'b0;
		end else if (step) begin
			sw_q    <= sw_d;
			bp_q    <= bp_d;
			sp_q    <= sp_d;
			fs_q    <= fs_d;
			side_q  <= side_d;
			press_q <= press_d;
			sdl_q   <= sdl_d;
			bdl_q   <= bdl_d;
			scnt_q  <= scnt_d;
			snl_q   <= snl_d;
			sos_q   <= sos_d;
			bst_q   <= bst_d;
			sl_q    <= sl_d;
			bl_q    <= bl_d;
		end
	end

endmodule

`default_nettype wire

// File: src/rc_switch_beacon_light_sequencer.sv
`default_nettype none

// channel   dir  signals                               contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser      one sample request
// m_*       out  m_tvalid m_tready m_tdata              one light state per request
// cfg_*     in   cfg_we cfg_addr cfg_data               register write, no read-back
//
// One request per clock while m_tready is high; input register, then result register.
// All state updates happen in one pass of the next-state logic between the two.
// arst_n clears all light, switch and sequence state and loads register defaults.
// A full result register with m_tready low holds; the input register still takes
// one more request, then s_tready drops.

module rc_switch_beacon_light_sequencer #(
	parameter int TOGGLE_STEPS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // now_us[31:0], channel_value[43:32], headlights_on[44]
	input  wire logic [1:0]  s_tuser,   // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// small_beacon_on[0], big_beacon_on[1], side_mode[3:2], search_light_on[4],
	// fog_lamp_on[5], big_phase_out[8:6], small_phase_out[11:9], switch_phase_out[14:12]
	output logic [15:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [30:0] cfg_data
);

	rcsb_pkg::cfg_t  cfg;
	rcsb_pkg::item_t item_s1;
	rcsb_pkg::res_t  res;
	rcsb_pkg::res_t  res_q;
	logic            valid_s1;
	logic            out_free;
	logic            step;
	logic            s_accept;

	assign out_free = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_free)
				m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.op            <= s_tuser;
			item_s1.now_us        <= s_tdata[31:0];
			item_s1.channel_value <= s_tdata[43:32];
			item_s1.headlights_on <= s_tdata[44];
		end
		if (step)
			res_q <= res;
	end

	rcsb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rcsb_core #(
		.TOGGLE_STEPS (TOGGLE_STEPS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tdata = {1'b0, res_q};

endmodule

`default_nettype wire
